### src/ctsrgb_pkg.sv
package ctsrgb_pkg;

    localparam logic [1:0] FMT_RGBA8   = 2'd0;
    localparam logic [1:0] FMT_BGRA8   = 2'd1;
    localparam logic [1:0] FMT_RGBA16F = 2'd2;

    // half codes in [0,1] fit in 14 bits (1.0 is 0x3C00)
    localparam int CODE_W = 14;
    localparam logic [CODE_W-1:0] HALF_ONE    = 14'h3C00;
    localparam logic [CODE_W-1:0] LINEAR_LAST = 14'h1A69;
    localparam logic [14:0]       HALF_INF    = 15'h7C00;

    // one binary search stage per output bit
    localparam int SEARCH_STAGES = 8;

    typedef struct packed {
        logic [15:0] first_channel;
        logic [15:0] second_channel;
        logic [15:0] third_channel;
    } texel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] value;
    } lane_res_t;

    typedef logic [255:0][CODE_W-1:0] thresh_t;
    typedef logic [383:0] big_t;

    // Exact test: is the encoded value of half code at least v - 0.5?
    function automatic logic reaches(input logic [CODE_W-1:0] code, input int unsigned v);
        logic [4:0]  e;
        logic [9:0]  f;
        logic [63:0] m;
        int unsigned s;
        logic [63:0] lhs_s;
        logic [63:0] rhs_s;
        big_t        lhs;
        big_t        rhs;
        e = {1'b0, code[13:10]};
        f = code[9:0];
        m = (e != 5'd0) ? (64'd1024 + 64'(f)) : 64'(f);
        s = (e != 5'd0) ? (25 - int'(e)) : 24;
        if (code <= LINEAR_LAST)
        begin
            lhs_s = m * 64'd65892;
            rhs_s = (64'((2 * v) - 1) * 64'd10) << s;
            return lhs_s >= rhs_s;
        end
        lhs = big_t'(1);
        rhs = big_t'(1);
        for (int i = 0; i < 12; i++)
        begin
            lhs = lhs * big_t'(53805);
            rhs = rhs * big_t'((200 * v) + 2705);
        end
        for (int i = 0; i < 5; i++)
        begin
            lhs = lhs * big_t'(m);
        end
        rhs = rhs << (5 * s);
        return lhs >= rhs;
    endfunction

    // T[v] = first half code whose encoded byte is at least v; T[0] = 0.
    function automatic thresh_t build_thresh();
        thresh_t     t;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        t = '0;
        for (int unsigned v = 1; v < 256; v++)
        begin
            lo = 0;
            hi = int'(HALF_ONE);
            for (int i = 0; i < 16; i++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi) >> 1;
                    if (reaches(CODE_W'(mid), v))
                        hi = mid;
                    else
                        lo = mid + 1;
                end
            end
            t[v] = CODE_W'(lo);
        end
        return t;
    endfunction

    localparam thresh_t SRGB_THRESH = build_thresh();

endpackage

### src/capture_texel_to_srgb8.sv
// Texel to 8-bit sRGB pixel converter.
// Input: a transaction is taken on each clock edge with start high and busy
// low; texel carries three 16-bit channels. busy is always low, so one texel
// can be issued every clock.
// Output: pixel is valid for exactly one cycle while done is high; alpha is
// always 255. The receiver cannot stall and must take each pixel then.
// Pipeline: input register, eight binary search stages over the curve
// threshold table, output register. The search depth is set by the 8-bit
// result width; all three channels run in parallel lanes, so throughput
// is one texel per cycle.
// Config: cfg_we writes cfg_data into the format register (0 RGBA8,
// 1 BGRA8, 2 RGBA half float, 3 acts as RGBA8). Write it only while no
// transaction is in flight.
// Reset: clears the format to RGBA8 and drops all in-flight transactions.
module capture_texel_to_srgb8 import ctsrgb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  texel_t     texel,
    output logic       done,
    output pixel_t     pixel,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data
);

    logic [1:0]  pixel_format_reg;
    logic        accept;
    logic        is_half;
    logic [15:0] chan_r;
    logic [15:0] chan_g;
    logic [15:0] chan_b;
    lane_res_t   res_r;
    lane_res_t   res_g;
    lane_res_t   res_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_format_reg <= FMT_RGBA8;
        else if (cfg_we)
            pixel_format_reg <= cfg_data;
    end

    assign busy    = 1'b0;
    assign accept  = start & ~busy;
    assign is_half = (pixel_format_reg == FMT_RGBA16F);

    always_comb
    begin
        case (pixel_format_reg)
            FMT_BGRA8:
            begin
                chan_r = texel.third_channel;
                chan_b = texel.first_channel;
            end
            default:
            begin
                chan_r = texel.first_channel;
                chan_b = texel.third_channel;
            end
        endcase
        chan_g = texel.second_channel;
    end

    ctsrgb_lane u_lane_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .is_half  (is_half),
        .chan     (chan_r),
        .res      (res_r)
    );

    ctsrgb_lane u_lane_g (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .is_half  (is_half),
        .chan     (chan_g),
        .res      (res_g)
    );

    ctsrgb_lane u_lane_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .is_half  (is_half),
        .chan     (chan_b),
        .res      (res_b)
    );

    ctsrgb_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .res_r (res_r),
        .res_g (res_g),
        .res_b (res_b),
        .done  (done),
        .pixel (pixel)
    );

endmodule

### src/ctsrgb_lane.sv
module ctsrgb_lane import ctsrgb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        is_half,
    input  logic [15:0] chan,
    output lane_res_t   res
);

    logic              valid_reg  [0:SEARCH_STAGES];
    logic              table_reg  [0:SEARCH_STAGES];
    logic [7:0]        forced_reg [0:SEARCH_STAGES];
    logic [7:0]        acc_reg    [0:SEARCH_STAGES];
    logic [CODE_W-1:0] code_reg   [0:SEARCH_STAGES-1];

    logic              table_next;
    logic [7:0]        forced_next;
    logic [CODE_W-1:0] code_next;
    logic [7:0]        acc_next   [1:SEARCH_STAGES];

    // classify the incoming channel
    always_comb
    begin
        table_next  = 1'b0;
        forced_next = chan[7:0];
        code_next   = chan[CODE_W-1:0];
        if (is_half)
        begin
            if (chan[15] || (chan[14:0] > HALF_INF))
                forced_next = 8'd0;
            else if (chan[14:0] > {1'b0, HALF_ONE})
                forced_next = 8'd255;
            else
                table_next = 1'b1;
        end
    end

    // one bit of the byte per stage, MSB first
    always_comb
    begin
        logic [7:0] cand;
        for (int k = 0; k < SEARCH_STAGES; k++)
        begin
            cand = acc_reg[k] | 8'(8'd1 << (SEARCH_STAGES - 1 - k));
            if (SRGB_THRESH[cand] <= code_reg[k])
                acc_next[k+1] = cand;
            else
                acc_next[k+1] = acc_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SEARCH_STAGES; k++)
                valid_reg[k] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= SEARCH_STAGES; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        table_reg[0]  <= table_next;
        forced_reg[0] <= forced_next;
        code_reg[0]   <= code_next;
        acc_reg[0]    <= 8'd0;
        for (int k = 1; k <= SEARCH_STAGES; k++)
        begin
            table_reg[k]  <= table_reg[k-1];
            forced_reg[k] <= forced_reg[k-1];
            acc_reg[k]    <= acc_next[k];
        end
        for (int k = 1; k < SEARCH_STAGES; k++)
            code_reg[k] <= code_reg[k-1];
    end

    assign res.valid = valid_reg[SEARCH_STAGES];
    assign res.value = table_reg[SEARCH_STAGES] ? acc_reg[SEARCH_STAGES]
                                                : forced_reg[SEARCH_STAGES];

endmodule

### src/ctsrgb_merge.sv
module ctsrgb_merge import ctsrgb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  lane_res_t res_r,
    input  lane_res_t res_g,
    input  lane_res_t res_b,
    output logic      done,
    output pixel_t    pixel
);

    logic   done_reg;
    logic   done_next;
    pixel_t pixel_reg;
    pixel_t pixel_next;

    always_comb
    begin
        done_next        = res_r.valid & res_g.valid & res_b.valid;
        pixel_next.red   = res_r.value;
        pixel_next.green = res_g.value;
        pixel_next.blue  = res_b.value;
        pixel_next.alpha = 8'd255;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign done  = done_reg;
    assign pixel = pixel_reg;

endmodule
